### design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions for the double-ended queue unit
// Operation and status codes, cell commands, controller states and the
// control beat handed from the controller to each storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;

   // operation codes; anything above list also lists
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // what every cell does this cycle
   typedef enum logic [2:0] {
      CMD_HOLD,         // keep contents
      CMD_SHIFT_BACK,   // take left neighbor; selected cell loads the new value
      CMD_LOAD,         // selected cell loads the new value, others hold
      CMD_SHIFT_FRONT,  // take right neighbor
      CMD_ROTATE        // take right neighbor; selected cell takes the head
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         sel;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_LISTING
   } ctrl_state_type;

endpackage

`default_nettype wire

### design/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell: one storage slot of the queue chain
// Holds one entry and moves it toward the front or back of the chain
// under the shared command, or loads a new value when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell (
   input  wire                              clock,
   input  wire deq_pkg::cell_ctrl_type      ctrl,
   input  wire logic signed [deq_pkg::DATA_W-1:0] value_in,
   input  wire logic signed [deq_pkg::DATA_W-1:0] left_in,
   input  wire logic signed [deq_pkg::DATA_W-1:0] right_in,
   input  wire logic signed [deq_pkg::DATA_W-1:0] head_in,
   output logic signed [deq_pkg::DATA_W-1:0]      data_out
);

   logic signed [deq_pkg::DATA_W-1:0] data_ff;
   logic signed [deq_pkg::DATA_W-1:0] data_in;

   // next contents
   always_comb begin
      case (ctrl.cmd)
         deq_pkg::CMD_HOLD:        data_in = data_ff;
         deq_pkg::CMD_SHIFT_BACK:  data_in = ctrl.sel ? value_in : left_in;
         deq_pkg::CMD_LOAD:        data_in = ctrl.sel ? value_in : data_ff;
         deq_pkg::CMD_SHIFT_FRONT: data_in = right_in;
         deq_pkg::CMD_ROTATE:      data_in = ctrl.sel ? head_in : right_in;
         default:                  data_in = data_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

### design/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue of signed words
// Entries sit in a chain of cells, front at cell 0. A push shifts the chain or
// loads one cell, a front pop shifts it; a list rotates it past cell 0.
//
//   channel  ports                                   flow
//   request  start, busy, req_operation, req_value   start & !busy takes a beat
//   response rsp_valid, rsp_item_value, rsp_status,  one-cycle strobe, no stall
//            rsp_last
//
// A push or pop response appears the cycle after its beat is taken, and a new
// beat can be taken every cycle while busy is low.
// A list of N entries keeps busy high while the chain rotates one cell per
// cycle; the N responses, registered from cell 0, follow front first.
// Reset clears the count, state and response valid only; cell contents are
// undefined and no clearing pass is run. The receiver cannot stall the responses.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     start,
   output logic                                    busy,
   input  wire logic [deq_pkg::OP_W-1:0]           req_operation,
   input  wire logic signed [deq_pkg::DATA_W-1:0]  req_value,
   output logic                                    rsp_valid,
   output logic signed [deq_pkg::DATA_W-1:0]       rsp_item_value,
   output logic [deq_pkg::STATUS_W-1:0]            rsp_status,
   output logic                                    rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   deq_pkg::ctrl_state_type state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [IW-1:0]           list_cnt_ff, list_cnt_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [deq_pkg::DATA_W-1:0]   rsp_item_ff, rsp_item_in;
   logic [deq_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic                                rsp_last_ff, rsp_last_in;

   deq_pkg::cell_cmd_type               cmd;
   deq_pkg::cell_ctrl_type              ctrl [DEPTH];
   logic signed [deq_pkg::DATA_W-1:0]   cell_data [DEPTH];

   logic accept;
   logic full;
   logic empty;
   logic list_done;

   assign accept    = start && (state_ff == deq_pkg::ST_IDLE);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign list_done = ((CW'(list_cnt_ff) + CW'(1)) == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (accept && !empty && (req_operation inside {[deq_pkg::OP_LIST:3'd7]})) begin
               state_in = deq_pkg::ST_LISTING;
            end
         end
         deq_pkg::ST_LISTING: begin
            if (list_done) begin
               state_in = deq_pkg::ST_IDLE;
            end
         end
         default: state_in = deq_pkg::ST_IDLE;
      endcase
   end

   // cell command, count and response
   always_comb begin
      cmd           = deq_pkg::CMD_HOLD;
      count_in      = count_ff;
      list_cnt_in   = list_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = '0;
      rsp_status_in = deq_pkg::ST_OK;
      rsp_last_in   = 1'b1;
      case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = deq_pkg::ST_FULL;
                     end else begin
                        cmd = (req_operation == deq_pkg::OP_PUSH_FRONT) ?
                              deq_pkg::CMD_SHIFT_BACK : deq_pkg::CMD_LOAD;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (empty) begin
                        rsp_status_in = deq_pkg::ST_EMPTY;
                     end else begin
                        if (req_operation == deq_pkg::OP_POP_FRONT) begin
                           cmd = deq_pkg::CMD_SHIFT_FRONT;
                        end
                        count_in = count_ff - CW'(1);
                     end
                  end
                  default: begin
                     // list: empty answers at once, otherwise start rotating
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = deq_pkg::ST_EMPTY;
                     end
                     list_cnt_in = '0;
                  end
               endcase
            end
         end
         deq_pkg::ST_LISTING: begin
            cmd          = deq_pkg::CMD_ROTATE;
            rsp_valid_in = 1'b1;
            rsp_item_in  = cell_data[0];
            rsp_last_in  = list_done;
            list_cnt_in  = list_cnt_ff + IW'(1);
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      list_cnt_ff   <= list_cnt_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // chain of cells; the select line marks the insertion or wrap point
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic sel;
      always_comb begin
         case (cmd)
            deq_pkg::CMD_SHIFT_BACK: sel = (k == 0);
            deq_pkg::CMD_LOAD:       sel = (count_ff == CW'(k));
            deq_pkg::CMD_ROTATE:     sel = (count_ff == CW'(k + 1));
            default:                 sel = 1'b0;
         endcase
      end
      assign ctrl[k] = '{cmd: cmd, sel: sel};

      deq_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl[k]),
         .value_in (req_value),
         .left_in  ((k == 0) ? cell_data[k] : cell_data[(k == 0) ? 0 : k - 1]),
         .right_in ((k == DEPTH - 1) ? cell_data[k] :
                    cell_data[(k == DEPTH - 1) ? k : k + 1]),
         .head_in  (cell_data[0]),
         .data_out (cell_data[k])
      );
   end

   assign busy           = (state_ff == deq_pkg::ST_LISTING);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_value = rsp_item_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef ASSERT_OFF
   // occupancy stays within the chain
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("occupancy above depth");

   // listing only runs over a non-empty queue
   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy |-> !empty)
      else $error("listing an empty queue");

   // every listing cycle yields a response beat
   a_list_beat: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("listing cycle without response");

   // a dropped push leaves the queue full
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == deq_pkg::ST_FULL) |-> full)
      else $error("full status but queue not full");
`endif

endmodule

`default_nettype wire

### bench/deq_response_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deq_response_checker: response checker for the double-ended queue unit
// Watches the request and response channels. Every request beat taken is run
// through a ring-buffer model of the queue. The responses it should give are
// queued, and each response strobe is compared with the oldest of them.
// ----------------------------------------------------------------------------

module deq_response_checker #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     start,
   input  wire                                     busy,
   input  wire logic [deq_pkg::OP_W-1:0]           req_operation,
   input  wire logic signed [deq_pkg::DATA_W-1:0]  req_value,
   input  wire                                     rsp_valid,
   input  wire logic signed [deq_pkg::DATA_W-1:0]  rsp_item_value,
   input  wire logic [deq_pkg::STATUS_W-1:0]       rsp_status,
   input  wire                                     rsp_last,
   output int                                      mismatch_count,
   output int                                      pending_count,
   output int                                      checked_count,
   output int                                      full_drop_count,
   output int                                      empty_hit_count
);

   typedef struct {
      logic signed [deq_pkg::DATA_W-1:0] item_value;
      logic [deq_pkg::STATUS_W-1:0]      status;
      logic                              last;
   } deq_response_type;

   // model state: ring store, front pointer, fill level
   logic signed [deq_pkg::DATA_W-1:0] ring_mem [DEPTH];
   int                                head_ptr;
   int                                fill_level;

   deq_response_type                  expected_responses [$];

   initial begin
      mismatch_count  = 0;
      pending_count   = 0;
      checked_count   = 0;
      full_drop_count = 0;
      empty_hit_count = 0;
      head_ptr        = 0;
      fill_level      = 0;
   end

   task automatic queue_response(input logic signed [deq_pkg::DATA_W-1:0] item,
                                 input logic [deq_pkg::STATUS_W-1:0] status,
                                 input logic last);
      deq_response_type entry;
      entry.item_value = item;
      entry.status     = status;
      entry.last       = last;
      expected_responses.push_back(entry);
      if (status == deq_pkg::ST_FULL) full_drop_count++;
      if (status == deq_pkg::ST_EMPTY) empty_hit_count++;
   endtask

   // advance the queue model by one operation and queue its responses
   task automatic predict_responses(input logic [deq_pkg::OP_W-1:0] op,
                                    input logic signed [deq_pkg::DATA_W-1:0] val);
      case (op)
         deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
            if (fill_level >= DEPTH) begin
               queue_response('0, deq_pkg::ST_FULL, 1'b1);
            end else begin
               if (op == deq_pkg::OP_PUSH_FRONT) begin
                  head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
                  ring_mem[head_ptr] = val;
               end else begin
                  ring_mem[(head_ptr + fill_level) % DEPTH] = val;
               end
               fill_level++;
               queue_response('0, deq_pkg::ST_OK, 1'b1);
            end
         end
         deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
            if (fill_level == 0) begin
               queue_response('0, deq_pkg::ST_EMPTY, 1'b1);
            end else begin
               if (op == deq_pkg::OP_POP_FRONT) head_ptr = (head_ptr + 1) % DEPTH;
               fill_level--;
               queue_response('0, deq_pkg::ST_OK, 1'b1);
            end
         end
         // list, and the three codes above it that alias list
         default: begin
            if (fill_level == 0) begin
               queue_response('0, deq_pkg::ST_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < fill_level; i++)
                  queue_response(ring_mem[(head_ptr + i) % DEPTH], deq_pkg::ST_OK,
                                 (i == fill_level - 1));
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input deq_response_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t MISMATCH %s: expected value %0d status %0d last %0d,",
                  $realtime, what, want.item_value, want.status, want.last,
                  " got value %0d status %0d last %0d",
                  rsp_item_value, rsp_status, rsp_last);
   endtask

   // compare one response beat against the oldest outstanding expectation
   task automatic check_response();
      deq_response_type want;
      if (expected_responses.size() == 0) begin
         want.item_value = 'x;
         want.status     = 'x;
         want.last       = 1'bx;
         report_mismatch("response with nothing outstanding", want);
      end else begin
         want = expected_responses.pop_front();
         checked_count++;
         if (want.item_value !== rsp_item_value)
            report_mismatch("item_value", want);
         else if (want.status !== rsp_status)
            report_mismatch("status", want);
         else if (want.last !== rsp_last)
            report_mismatch("last", want);
      end
   endtask

   // request beats are modeled before the response check of the same edge
   always @(posedge clock) begin
      if (reset) begin
         head_ptr   = 0;
         fill_level = 0;
         expected_responses.delete();
      end else begin
         if (start && !busy) predict_responses(req_operation, req_value);
         if (rsp_valid) check_response();
      end
      pending_count = expected_responses.size();
   end

endmodule

### bench/double_ended_queue_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_test: top-level bench for the double-ended queue
// Drives directed corner cases (empty pops and lists, extreme values, a full
// queue, list code aliases) and then bursts of random operations that fill,
// drain and list the queue under three sender idle profiles. Checking is done
// by deq_response_checker; this module only drives and reports.
// ----------------------------------------------------------------------------

module double_ended_queue_unit_test;

   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 24;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic [deq_pkg::OP_W-1:0]          req_operation = deq_pkg::OP_PUSH_FRONT;
   logic signed [deq_pkg::DATA_W-1:0] req_value = '0;

   logic                              busy;
   logic                              rsp_valid;
   logic signed [deq_pkg::DATA_W-1:0] rsp_item_value;
   logic [deq_pkg::STATUS_W-1:0]      rsp_status;
   logic                              rsp_last;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int full_drop_count;
   int empty_hit_count;

   int idle_pct    = 0;
   int stall_count = 0;
   int push_beats  = 0;
   int pop_beats   = 0;
   int list_beats  = 0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   double_ended_queue_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   deq_response_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_item_value  (rsp_item_value),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .full_drop_count (full_drop_count),
      .empty_hit_count (empty_hit_count)
   );

   // watchdog: too long without a request or response beat ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, pending_count);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // present one request beat, after an optional random gap, and hold it
   // until taken; returns in the time step of the accepting edge
   task automatic send_beat(input logic [deq_pkg::OP_W-1:0] op,
                            input logic signed [deq_pkg::DATA_W-1:0] val);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      do @(posedge clock); while (busy);
      case (op)
         deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: push_beats++;
         deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:   pop_beats++;
         default:                                       list_beats++;
      endcase
   endtask

   // stop sending until every outstanding response has arrived
   task automatic hold_until_drained();
      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // random word, with the extremes and all-zero/all-one mixed in
   function automatic logic signed [deq_pkg::DATA_W-1:0] rand_word();
      case ($urandom_range(0, 11))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // bursts that lean toward filling, draining or mixing the queue
   task automatic run_random_phase(input int item_total, input int gap_pct);
      int sent;
      int burst_left;
      int push_share;
      int list_share;
      int pick;
      logic [deq_pkg::OP_W-1:0] op;
      sent       = 0;
      burst_left = 0;
      push_share = 40;
      list_share = 20;
      idle_pct   = gap_pct;
      while (sent < item_total) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(10, 30);
            case ($urandom_range(0, 2))
               0:       begin push_share = 75; list_share = 10; end
               1:       begin push_share = 15; list_share = 10; end
               default: begin push_share = 40; list_share = 20; end
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < push_share)
            op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
         else if (pick < 100 - list_share)
            op = $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
         else
            op = deq_pkg::OP_LIST | deq_pkg::OP_W'($urandom_range(0, 3));
         send_beat(op, rand_word());
         sent++;
         burst_left--;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty queue: list, list alias, both pops
      send_beat(deq_pkg::OP_LIST, rand_word());
      send_beat(deq_pkg::OP_LIST | deq_pkg::OP_POP_BACK, rand_word());
      send_beat(deq_pkg::OP_POP_FRONT, rand_word());
      send_beat(deq_pkg::OP_POP_BACK, rand_word());

      // extremes at both ends, list through an alias, pop both ends
      send_beat(deq_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_beat(deq_pkg::OP_PUSH_BACK, 32'sh8000_0000);
      send_beat(deq_pkg::OP_LIST | deq_pkg::OP_PUSH_BACK, rand_word());
      send_beat(deq_pkg::OP_POP_FRONT, rand_word());
      send_beat(deq_pkg::OP_POP_BACK, rand_word());

      // fill to capacity from both ends, then push into a full queue
      for (int i = 0; i < deq_pkg::DEPTH_DEFAULT; i++) begin
         case (i)
            0:       send_beat(deq_pkg::OP_PUSH_FRONT, '0);
            1:       send_beat(deq_pkg::OP_PUSH_BACK, '1);
            2:       send_beat(deq_pkg::OP_PUSH_FRONT, 32'shAAAA_AAAA);
            3:       send_beat(deq_pkg::OP_PUSH_BACK, 32'sh5555_5555);
            default: send_beat((i % 2) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                               $urandom);
         endcase
      end
      send_beat(deq_pkg::OP_PUSH_FRONT, rand_word());
      send_beat(deq_pkg::OP_PUSH_BACK, rand_word());
      send_beat(deq_pkg::OP_LIST | deq_pkg::OP_POP_FRONT, rand_word());
      hold_until_drained();

      // random bursts: light sender gaps, heavy gaps, then back to back
      run_random_phase(117, 14);
      hold_until_drained();
      run_random_phase(117, 82);
      hold_until_drained();
      run_random_phase(118, 0);
      hold_until_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("Sent %0d beats: %0d pushes, %0d pops, %0d lists (codes 4 to 7)",
               push_beats + pop_beats + list_beats, push_beats, pop_beats, list_beats);
      $display("Checked %0d responses, %0d full-queue drops, %0d empty-queue hits",
               checked_count, full_drop_count, empty_hit_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### filelist.f
design/deq_pkg.sv
design/deq_cell.sv
design/double_ended_queue_unit.sv
bench/deq_response_checker.sv
bench/double_ended_queue_unit_test.sv
